>>> sv/hrsp_pkg.sv
// Package for the HTTP request stream parser: parser state codes, token kinds,
// status codes and header-name match helpers. No dependencies.
`default_nettype none
package hrsp_pkg;

  localparam int unsigned LengthBitsDefault = 32;

  typedef enum logic [4:0] {
    P_START, P_METHOD, P_BEFORE_PATH, P_PATH, P_BEFORE_QUERY, P_QKEY,
    P_BEFORE_QVAL, P_QVAL, P_BEFORE_PROTO, P_PROTO, P_BEFORE_VER, P_VER,
    P_CR, P_CRLF, P_HKEY, P_HBEFORE_COLON, P_HAFTER_COLON, P_HVAL,
    P_CRLF_CR, P_BODY, P_COMPLETE, P_INVALID
  } parse_state_t;

  typedef enum logic [1:0] {C_START, C_KEY, C_BEFORE_VALUE, C_VALUE} cookie_state_t;

  localparam logic [3:0] K_NONE    = 4'd0;
  localparam logic [3:0] K_METHOD  = 4'd1;
  localparam logic [3:0] K_PATH    = 4'd2;
  localparam logic [3:0] K_QKEY    = 4'd3;
  localparam logic [3:0] K_QVAL    = 4'd4;
  localparam logic [3:0] K_PROTO   = 4'd5;
  localparam logic [3:0] K_VERSION = 4'd6;
  localparam logic [3:0] K_HKEY    = 4'd7;
  localparam logic [3:0] K_HVAL    = 4'd8;
  localparam logic [3:0] K_CKEY    = 4'd9;
  localparam logic [3:0] K_CVAL    = 4'd10;
  localparam logic [3:0] K_BODY    = 4'd11;

  localparam logic [1:0] S_RUNNING  = 2'd0;
  localparam logic [1:0] S_COMPLETE = 2'd1;
  localparam logic [1:0] S_INVALID  = 2'd2;

  localparam int unsigned LenClName   = 14;
  localparam int unsigned LenConnName = 10;
  localparam int unsigned LenCookie   = 6;
  localparam int unsigned LenKeep     = 10;

  function automatic logic [7:0] name_cl(input logic [3:0] p);
    case (p)
      4'd0: name_cl = "c";  4'd1: name_cl = "o";  4'd2: name_cl = "n";
      4'd3: name_cl = "t";  4'd4: name_cl = "e";  4'd5: name_cl = "n";
      4'd6: name_cl = "t";  4'd7: name_cl = "-";  4'd8: name_cl = "l";
      4'd9: name_cl = "e";  4'd10: name_cl = "n"; 4'd11: name_cl = "g";
      4'd12: name_cl = "t"; 4'd13: name_cl = "h";
      default: name_cl = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] name_conn(input logic [3:0] p);
    case (p)
      4'd0: name_conn = "c"; 4'd1: name_conn = "o"; 4'd2: name_conn = "n";
      4'd3: name_conn = "n"; 4'd4: name_conn = "e"; 4'd5: name_conn = "c";
      4'd6: name_conn = "t"; 4'd7: name_conn = "i"; 4'd8: name_conn = "o";
      4'd9: name_conn = "n";
      default: name_conn = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] name_cookie(input logic [3:0] p);
    case (p)
      4'd0: name_cookie = "c"; 4'd1: name_cookie = "o"; 4'd2: name_cookie = "o";
      4'd3: name_cookie = "k"; 4'd4: name_cookie = "i"; 4'd5: name_cookie = "e";
      default: name_cookie = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] word_keep(input logic [3:0] p);
    case (p)
      4'd0: word_keep = "k"; 4'd1: word_keep = "e"; 4'd2: word_keep = "e";
      4'd3: word_keep = "p"; 4'd4: word_keep = "-"; 4'd5: word_keep = "a";
      4'd6: word_keep = "l"; 4'd7: word_keep = "i"; 4'd8: word_keep = "v";
      4'd9: word_keep = "e";
      default: word_keep = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    to_lower = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

endpackage
`default_nettype wire

>>> sv/http_request_stream_parser.sv
// HTTP request stream parser top level: byte tagger with registered input
// and output stages. Depends on hrsp_pkg.
//
// One request byte enters per cycle and its tagged result leaves from the
// result register; the input holds a byte in a register, one pass of parser
// state logic sets the result register, so a byte can be taken every cycle
// as long as the output side drains. Content-Length is a saturating decimal
// of LENGTH_BITS bits; its digit step is a shift-add with one compare.
`default_nettype none
module http_request_stream_parser #(
  parameter int unsigned LENGTH_BITS = hrsp_pkg::LengthBitsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // data_byte
  input  wire logic        in_tlast,   // is_last
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // byte_out, token_kind, token_first,
                                       // closed_kind, parse_status, keep_alive
  output logic             out_tlast   // last_out
);

  localparam logic [LENGTH_BITS-1:0] LenMax = {LENGTH_BITS{1'b1}};

  logic                  cfg_ka_r;
  logic                  a_vld_r;
  logic [7:0]            a_byte_r;
  logic                  a_last_r;
  logic                  o_vld_r;
  logic [23:0]           o_data_r;
  logic                  o_last_r;

  hrsp_pkg::parse_state_t  ps_r, ps_nxt;
  hrsp_pkg::cookie_state_t cs_r, cs_nxt;
  logic [3:0]             kpos_r, kpos_nxt;
  logic [2:0]             kfl_r, kfl_nxt;
  logic [3:0]             vpos_r, vpos_nxt;
  logic                   vfl_r, vfl_nxt;
  logic                   lseen_r, lseen_nxt;
  logic [LENGTH_BITS-1:0] clen_r, clen_nxt;
  logic                   cseen_r, cseen_nxt;
  logic                   kaf_r, kaf_nxt;
  logic [LENGTH_BITS-1:0] brem_r, brem_nxt;

  logic [3:0] kind, closed;
  logic       first;
  logic [1:0] status;
  logic       step;
  logic       a_take;

  assign step      = a_vld_r && (!o_vld_r || out_tready);
  assign in_tready = !a_vld_r || step;
  assign a_take    = in_tvalid && in_tready;

  logic [7:0] c, lc;
  logic       blank, crlf, upper, digit;
  logic [LENGTH_BITS+3:0] mul10;
  logic [LENGTH_BITS+3:0] dsum;

  always_comb begin
    logic [3:0] p;
    logic [LENGTH_BITS-1:0] cl;
    logic vf;
    c     = a_byte_r;
    lc    = hrsp_pkg::to_lower(c);
    blank = (c == " ") || (c == 8'h09);
    crlf  = (c == 8'h0d) || (c == 8'h0a);
    upper = (c >= "A") && (c <= "Z");
    digit = (c >= "0") && (c <= "9");
    ps_nxt = ps_r; cs_nxt = cs_r; kpos_nxt = kpos_r; kfl_nxt = kfl_r;
    vpos_nxt = vpos_r; vfl_nxt = vfl_r; lseen_nxt = lseen_r; clen_nxt = clen_r;
    cseen_nxt = cseen_r; kaf_nxt = kaf_r; brem_nxt = brem_r;
    kind = hrsp_pkg::K_NONE; first = 1'b0; closed = hrsp_pkg::K_NONE;
    mul10 = '0; dsum = '0;
    p = 4'd0; cl = '0; vf = 1'b0;
    case (ps_r)
      hrsp_pkg::P_START: begin
        if (!(blank || crlf)) begin
          if (upper) begin
            kind = hrsp_pkg::K_METHOD; first = 1'b1; ps_nxt = hrsp_pkg::P_METHOD;
          end else ps_nxt = hrsp_pkg::P_INVALID;
        end
      end
      hrsp_pkg::P_METHOD: begin
        if (upper) kind = hrsp_pkg::K_METHOD;
        else if (blank) begin
          closed = hrsp_pkg::K_METHOD; ps_nxt = hrsp_pkg::P_BEFORE_PATH;
        end else ps_nxt = hrsp_pkg::P_INVALID;
      end
      hrsp_pkg::P_BEFORE_PATH: begin
        if (!blank) begin
          if (c == "/") begin
            kind = hrsp_pkg::K_PATH; first = 1'b1; ps_nxt = hrsp_pkg::P_PATH;
          end else ps_nxt = hrsp_pkg::P_INVALID;
        end
      end
      hrsp_pkg::P_PATH: begin
        if (c == "?") begin
          closed = hrsp_pkg::K_PATH; ps_nxt = hrsp_pkg::P_BEFORE_QUERY;
        end else if (blank) begin
          closed = hrsp_pkg::K_PATH; ps_nxt = hrsp_pkg::P_BEFORE_PROTO;
        end else if (crlf) ps_nxt = hrsp_pkg::P_INVALID;
        else kind = hrsp_pkg::K_PATH;
      end
      hrsp_pkg::P_BEFORE_QUERY: begin
        if (blank || crlf) ps_nxt = hrsp_pkg::P_INVALID;
        else begin
          kind = hrsp_pkg::K_QKEY; first = 1'b1; ps_nxt = hrsp_pkg::P_QKEY;
        end
      end
      hrsp_pkg::P_QKEY: begin
        if (blank || crlf) ps_nxt = hrsp_pkg::P_INVALID;
        else if (c == "=") begin
          closed = hrsp_pkg::K_QKEY; ps_nxt = hrsp_pkg::P_BEFORE_QVAL;
        end else kind = hrsp_pkg::K_QKEY;
      end
      hrsp_pkg::P_BEFORE_QVAL: begin
        if (blank || crlf) ps_nxt = hrsp_pkg::P_INVALID;
        else begin
          kind = hrsp_pkg::K_QVAL; first = 1'b1; ps_nxt = hrsp_pkg::P_QVAL;
        end
      end
      hrsp_pkg::P_QVAL: begin
        if (crlf) ps_nxt = hrsp_pkg::P_INVALID;
        else if (blank) begin
          closed = hrsp_pkg::K_QVAL; ps_nxt = hrsp_pkg::P_BEFORE_PROTO;
        end else if (c == "&") begin
          closed = hrsp_pkg::K_QVAL; ps_nxt = hrsp_pkg::P_BEFORE_QUERY;
        end else kind = hrsp_pkg::K_QVAL;
      end
      hrsp_pkg::P_BEFORE_PROTO: begin
        if (!blank) begin
          if (crlf) ps_nxt = hrsp_pkg::P_INVALID;
          else begin
            kind = hrsp_pkg::K_PROTO; first = 1'b1; ps_nxt = hrsp_pkg::P_PROTO;
          end
        end
      end
      hrsp_pkg::P_PROTO: begin
        if (crlf) ps_nxt = hrsp_pkg::P_INVALID;
        else if (c == "/") begin
          closed = hrsp_pkg::K_PROTO; ps_nxt = hrsp_pkg::P_BEFORE_VER;
        end else kind = hrsp_pkg::K_PROTO;
      end
      hrsp_pkg::P_BEFORE_VER: begin
        if (digit) begin
          kind = hrsp_pkg::K_VERSION; first = 1'b1; ps_nxt = hrsp_pkg::P_VER;
        end else ps_nxt = hrsp_pkg::P_INVALID;
      end
      hrsp_pkg::P_VER: begin
        if (c == 8'h0d) begin
          closed = hrsp_pkg::K_VERSION; ps_nxt = hrsp_pkg::P_CR;
        end else kind = hrsp_pkg::K_VERSION;
      end
      hrsp_pkg::P_CR: begin
        ps_nxt = (c == 8'h0a) ? hrsp_pkg::P_CRLF : hrsp_pkg::P_INVALID;
      end
      hrsp_pkg::P_CRLF: begin
        if (c == 8'h0d) ps_nxt = hrsp_pkg::P_CRLF_CR;
        else if (blank) ps_nxt = hrsp_pkg::P_INVALID;
        else begin
          kind = hrsp_pkg::K_HKEY; first = 1'b1; ps_nxt = hrsp_pkg::P_HKEY;
          kfl_nxt[0] = (lc == hrsp_pkg::name_cl(4'd0));
          kfl_nxt[1] = (lc == hrsp_pkg::name_conn(4'd0));
          kfl_nxt[2] = (lc == hrsp_pkg::name_cookie(4'd0));
          kpos_nxt = 4'd1;
        end
      end
      hrsp_pkg::P_HKEY: begin
        if (blank || c == ":") begin
          closed = hrsp_pkg::K_HKEY;
          if (kpos_r != 4'(hrsp_pkg::LenClName))   kfl_nxt[0] = 1'b0;
          if (kpos_r != 4'(hrsp_pkg::LenConnName)) kfl_nxt[1] = 1'b0;
          if (kpos_r != 4'(hrsp_pkg::LenCookie))   kfl_nxt[2] = 1'b0;
          ps_nxt = blank ? hrsp_pkg::P_HBEFORE_COLON : hrsp_pkg::P_HAFTER_COLON;
        end else begin
          kind = hrsp_pkg::K_HKEY;
          if (kpos_r >= 4'(hrsp_pkg::LenClName) || lc != hrsp_pkg::name_cl(kpos_r))
            kfl_nxt[0] = 1'b0;
          if (kpos_r >= 4'(hrsp_pkg::LenConnName) || lc != hrsp_pkg::name_conn(kpos_r))
            kfl_nxt[1] = 1'b0;
          if (kpos_r >= 4'(hrsp_pkg::LenCookie) || lc != hrsp_pkg::name_cookie(kpos_r))
            kfl_nxt[2] = 1'b0;
          if (kpos_r != 4'd15) kpos_nxt = kpos_r + 4'd1;
        end
      end
      hrsp_pkg::P_HBEFORE_COLON: begin
        if (!blank)
          ps_nxt = (c == ":") ? hrsp_pkg::P_HAFTER_COLON : hrsp_pkg::P_INVALID;
      end
      hrsp_pkg::P_HAFTER_COLON, hrsp_pkg::P_HVAL: begin
        logic start;
        start = (ps_r == hrsp_pkg::P_HAFTER_COLON);
        if (ps_r == hrsp_pkg::P_HAFTER_COLON && blank) begin
        end else if (!start && c == 8'h0d) begin
          if (kfl_r[2]) begin
            closed = (cs_r == hrsp_pkg::C_KEY) ? hrsp_pkg::K_CKEY :
                     (cs_r == hrsp_pkg::C_VALUE) ? hrsp_pkg::K_CVAL : hrsp_pkg::K_NONE;
          end else begin
            closed = hrsp_pkg::K_HVAL;
            if (kfl_r[0] && !lseen_r) lseen_nxt = 1'b1;
            if (kfl_r[1] && !cseen_r) begin
              cseen_nxt = 1'b1;
              kaf_nxt = vfl_r && (vpos_r == 4'(hrsp_pkg::LenKeep));
            end
          end
          ps_nxt = hrsp_pkg::P_CR;
        end else if (kfl_r[2]) begin
          ps_nxt = hrsp_pkg::P_HVAL;
          case (start ? hrsp_pkg::C_START : cs_r)
            hrsp_pkg::C_START: begin
              cs_nxt = hrsp_pkg::C_START;
              if (!blank) begin
                kind = hrsp_pkg::K_CKEY; first = 1'b1; cs_nxt = hrsp_pkg::C_KEY;
              end
            end
            hrsp_pkg::C_KEY: begin
              if (c == "=") begin
                closed = hrsp_pkg::K_CKEY; cs_nxt = hrsp_pkg::C_BEFORE_VALUE;
              end else kind = hrsp_pkg::K_CKEY;
            end
            hrsp_pkg::C_BEFORE_VALUE: begin
              if (blank) ps_nxt = hrsp_pkg::P_INVALID;
              else begin
                kind = hrsp_pkg::K_CVAL; first = 1'b1; cs_nxt = hrsp_pkg::C_VALUE;
              end
            end
            default: begin
              if (c == ";") begin
                closed = hrsp_pkg::K_CVAL; cs_nxt = hrsp_pkg::C_START;
              end else kind = hrsp_pkg::K_CVAL;
            end
          endcase
        end else begin
          ps_nxt = hrsp_pkg::P_HVAL;
          kind = hrsp_pkg::K_HVAL; first = start;
          p  = start ? 4'd0 : vpos_r;
          vf = start ? 1'b1 : vfl_r;
          vpos_nxt = p; vfl_nxt = vf;
          if (kfl_r[1] && !cseen_r) begin
            if (p >= 4'(hrsp_pkg::LenKeep) || lc != hrsp_pkg::word_keep(p))
              vfl_nxt = 1'b0;
            if (p != 4'd15) vpos_nxt = p + 4'd1;
          end else if (kfl_r[0] && !lseen_r) begin
            cl = start ? '0 : clen_r;
            clen_nxt = cl;
            if (vf && digit) begin
              mul10 = {3'b000, cl, 1'b0} + {1'b0, cl, 3'b000};
              dsum  = mul10 + (LENGTH_BITS+4)'(c - "0");
              clen_nxt = (dsum > (LENGTH_BITS+4)'(LenMax)) ? LenMax
                                                           : dsum[LENGTH_BITS-1:0];
            end else vfl_nxt = 1'b0;
          end
        end
      end
      hrsp_pkg::P_CRLF_CR: begin
        if (c != 8'h0a) ps_nxt = hrsp_pkg::P_INVALID;
        else begin
          vfl_nxt = 1'b1;
          if (lseen_r) begin
            brem_nxt = clen_r;
            ps_nxt = (clen_r != '0) ? hrsp_pkg::P_BODY : hrsp_pkg::P_COMPLETE;
          end else ps_nxt = a_last_r ? hrsp_pkg::P_COMPLETE : hrsp_pkg::P_BODY;
        end
      end
      hrsp_pkg::P_BODY: begin
        kind = hrsp_pkg::K_BODY; first = vfl_r; vfl_nxt = 1'b0;
        if (lseen_r) begin
          brem_nxt = brem_r - 1'b1;
          if (brem_nxt == '0) ps_nxt = hrsp_pkg::P_COMPLETE;
        end else if (a_last_r) ps_nxt = hrsp_pkg::P_COMPLETE;
      end
      hrsp_pkg::P_COMPLETE: begin
      end
      default: ps_nxt = hrsp_pkg::P_INVALID;
    endcase
    if (ps_nxt == hrsp_pkg::P_COMPLETE) status = hrsp_pkg::S_COMPLETE;
    else if (ps_nxt == hrsp_pkg::P_INVALID || a_last_r) status = hrsp_pkg::S_INVALID;
    else status = hrsp_pkg::S_RUNNING;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_ka_r <= 1'b0;
      a_vld_r  <= 1'b0;
      o_vld_r  <= 1'b0;
      ps_r <= hrsp_pkg::P_START; cs_r <= hrsp_pkg::C_START;
      kpos_r <= '0; kfl_r <= 3'b111; vpos_r <= '0; vfl_r <= 1'b1;
      lseen_r <= 1'b0; clen_r <= '0; cseen_r <= 1'b0; kaf_r <= 1'b0; brem_r <= '0;
    end else begin
      if (cfg_we) cfg_ka_r <= cfg_wdata;
      if (in_tready) a_vld_r <= in_tvalid;
      if (step) o_vld_r <= 1'b1;
      else if (out_tready) o_vld_r <= 1'b0;
      if (step) begin
        if (a_last_r) begin
          ps_r <= hrsp_pkg::P_START; cs_r <= hrsp_pkg::C_START;
          kpos_r <= '0; kfl_r <= 3'b111; vpos_r <= '0; vfl_r <= 1'b1;
          lseen_r <= 1'b0; clen_r <= '0; cseen_r <= 1'b0; kaf_r <= 1'b0; brem_r <= '0;
        end else begin
          ps_r <= ps_nxt; cs_r <= cs_nxt; kpos_r <= kpos_nxt; kfl_r <= kfl_nxt;
          vpos_r <= vpos_nxt; vfl_r <= vfl_nxt; lseen_r <= lseen_nxt;
          clen_r <= clen_nxt; cseen_r <= cseen_nxt; kaf_r <= kaf_nxt;
          brem_r <= brem_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_take) begin
      a_byte_r <= in_tdata;
      a_last_r <= in_tlast;
    end
    if (step) begin
      o_data_r <= {4'b0000, (cseen_nxt ? kaf_nxt : cfg_ka_r), status, closed,
                   first, kind, c};
      o_last_r <= a_last_r;
    end
  end

  assign out_tvalid = o_vld_r;
  assign out_tdata  = o_data_r;
  assign out_tlast  = o_last_r;

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (a_vld_r && !step) |=> a_vld_r)
    else $error("input stage lost a byte");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (o_vld_r && !out_tready && !step) |=> $stable(o_data_r))
    else $error("result changed while stalled");
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (step && a_last_r) |=> (ps_r == hrsp_pkg::P_START))
    else $error("state not cleared after last byte");
  a_body_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (step && ps_r == hrsp_pkg::P_BODY) |=> (o_data_r[11:8] == hrsp_pkg::K_BODY))
    else $error("body byte not tagged");

endmodule
`default_nettype wire
